// File: hw/rtl/head_relative_wrist_pose_unit_defines.svh
// ----------------------------------------------------------------------------
// Head-relative wrist pose unit: assertion macros
// Shared assertion macros; defining NO_ASSERTIONS removes every check.
// ----------------------------------------------------------------------------
`ifndef HEAD_RELATIVE_WRIST_POSE_UNIT_DEFINES_SVH
`define HEAD_RELATIVE_WRIST_POSE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HRWP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hrwp check failed");
`define HRWP_ASSERT_ANY(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("hrwp check failed");
`else
`define HRWP_ASSERT(label, prop)
`define HRWP_ASSERT_ANY(label, prop)
`endif
`endif

// File: hw/rtl/hrwp_pkg.sv
// ----------------------------------------------------------------------------
// Head-relative wrist pose package
// Formats, metre constants, mount quaternions and shared helpers.
// ----------------------------------------------------------------------------
package hrwp_pkg;

    localparam int POS_FRAC_BITS  = 12;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int MOUNT_FRAC     = 30;

    localparam int D_W   = 16;
    localparam int SUM_W = 24;
    localparam int T_W   = 34;
    localparam int R_W   = 51;
    localparam int M_W   = 49;
    localparam int C_W   = 32;

    localparam logic signed [D_W-1:0] QUAT_ONE = D_W'(1 << QUAT_FRAC_BITS);

    localparam logic signed [D_W-1:0] HEAD_Y_MIN = D_W'((500 * (1 << POS_FRAC_BITS) + 500) / 1000);
    localparam logic signed [D_W-1:0] HEAD_Y_DEF = D_W'((1650 * (1 << POS_FRAC_BITS) + 500) / 1000);
    localparam logic signed [D_W-1:0] K600 = D_W'((600 * (1 << POS_FRAC_BITS) + 500) / 1000);
    localparam logic signed [D_W-1:0] K400 = D_W'((400 * (1 << POS_FRAC_BITS) + 500) / 1000);
    localparam logic signed [D_W-1:0] K750 = D_W'((750 * (1 << POS_FRAC_BITS) + 500) / 1000);
    localparam logic signed [D_W-1:0] K150 = D_W'((150 * (1 << POS_FRAC_BITS) + 500) / 1000);
    localparam logic signed [D_W-1:0] K220 = D_W'((220 * (1 << POS_FRAC_BITS) + 500) / 1000);
    localparam logic signed [D_W-1:0] K200 = D_W'((200 * (1 << POS_FRAC_BITS) + 500) / 1000);
    localparam logic signed [D_W-1:0] K350 = D_W'((350 * (1 << POS_FRAC_BITS) + 500) / 1000);

    localparam logic signed [D_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [D_W-1:0] SAT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        MQ_W = 2'd0,
        MQ_X = 2'd1,
        MQ_Y = 2'd2,
        MQ_Z = 2'd3
    } t_mq_idx;

    typedef struct packed {
        logic                  left;
        logic signed [D_W-1:0] hx;
        logic signed [D_W-1:0] hy;
        logic signed [D_W-1:0] hz;
        logic signed [D_W-1:0] qw;
        logic signed [D_W-1:0] qx;
        logic signed [D_W-1:0] qy;
        logic signed [D_W-1:0] qz;
        logic signed [D_W-1:0] vx;
        logic signed [D_W-1:0] vy;
        logic signed [D_W-1:0] vz;
    } t_cond;

    function automatic logic signed [C_W-1:0] mount_coef(input logic left, input t_mq_idx idx);
        logic signed [C_W-1:0] c;
        case (idx)
            MQ_W: c = 32'sd602617735;
            MQ_X: c = left ? 32'sd701339158 : -32'sd701339158;
            MQ_Y: c = -32'sd290785703;
            MQ_Z: c = left ? 32'sd461887827 : -32'sd461887827;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [D_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [D_W-1:0] s;
        if (v > SUM_W'(SAT_MAX)) begin
            s = SAT_MAX;
        end else if (v < SUM_W'(SAT_MIN)) begin
            s = SAT_MIN;
        end else begin
            s = v[D_W-1:0];
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/hrwp_cond.sv
// ----------------------------------------------------------------------------
// Head-relative wrist pose: input conditioning stage
// Replaces a low head height, clamps or defaults the wrist offset and turns a
// zero quaternion into identity, then registers the item.
// ----------------------------------------------------------------------------
`include "head_relative_wrist_pose_unit_defines.svh"

module hrwp_cond (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_left,
    input  logic signed [15:0]   i_head_x,
    input  logic signed [15:0]   i_head_y,
    input  logic signed [15:0]   i_head_z,
    input  logic signed [15:0]   i_head_qw,
    input  logic signed [15:0]   i_head_qx,
    input  logic signed [15:0]   i_head_qy,
    input  logic signed [15:0]   i_head_qz,
    input  logic signed [15:0]   i_wrist_x,
    input  logic signed [15:0]   i_wrist_y,
    input  logic signed [15:0]   i_wrist_z,
    input  logic                 i_wrist_tracked,
    output logic                 o_valid,
    output hrwp_pkg::t_cond      o_cond
);
    import hrwp_pkg::*;

    logic  r_valid;
    t_cond r_cond;
    t_cond n_cond;
    logic  ident;

    always_comb begin
        ident = (i_head_qw == '0) && (i_head_qx == '0) && (i_head_qy == '0)
                && (i_head_qz == '0);
        n_cond.left = i_left;
        n_cond.hx   = i_head_x;
        n_cond.hy   = (i_head_y < HEAD_Y_MIN) ? HEAD_Y_DEF : i_head_y;
        n_cond.hz   = i_head_z;
        n_cond.qw   = ident ? QUAT_ONE : i_head_qw;
        n_cond.qx   = i_head_qx;
        n_cond.qy   = i_head_qy;
        n_cond.qz   = i_head_qz;
        if (i_wrist_tracked) begin
            n_cond.vx = (i_wrist_x < -K600) ? -K600 : ((i_wrist_x > K600) ? K600 : i_wrist_x);
            n_cond.vy = (i_wrist_y < -K600) ? -K600 : ((i_wrist_y > K400) ? K400 : i_wrist_y);
            n_cond.vz = (i_wrist_z < -K750) ? -K750 : ((i_wrist_z > -K150) ? -K150 : i_wrist_z);
        end else begin
            n_cond.vx = i_left ? -K220 : K220;
            n_cond.vy = -K200;
            n_cond.vz = -K350;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_cond <= n_cond;
        end
    end

    assign o_valid = r_valid;
    assign o_cond  = r_cond;

    `HRWP_ASSERT(no_zero_quat_a,
        r_valid |-> ((r_cond.qw != '0) || (r_cond.qx != '0) || (r_cond.qy != '0)
                     || (r_cond.qz != '0)))

endmodule

// File: hw/rtl/hrwp_rot.sv
// ----------------------------------------------------------------------------
// Head-relative wrist pose: offset rotation pipeline
// Three stages: t = q * (0, v), r = t * conj(q), then rounding, head
// translation and saturation.
// ----------------------------------------------------------------------------
module hrwp_rot (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  hrwp_pkg::t_cond      i_cond,
    output logic                 o_valid,
    output logic signed [15:0]   o_pose_x,
    output logic signed [15:0]   o_pose_y,
    output logic signed [15:0]   o_pose_z
);
    import hrwp_pkg::*;

    localparam int SH = 2 * QUAT_FRAC_BITS;
    localparam logic signed [R_W-1:0] HALF = R_W'(1) <<< (SH - 1);

    logic                  r_v2, r_v3, r_v4;
    t_cond                 r_c2, r_c3;
    logic signed [T_W-1:0] r_tw, r_tx, r_ty, r_tz;
    logic signed [T_W-1:0] n_tw, n_tx, n_ty, n_tz;
    logic signed [R_W-1:0] r_rx, r_ry, r_rz;
    logic signed [R_W-1:0] n_rx, n_ry, n_rz;
    logic signed [D_W-1:0] r_px, r_py, r_pz;
    logic signed [D_W-1:0] n_px, n_py, n_pz;

    function automatic logic signed [SUM_W-1:0] rnd(input logic signed [R_W-1:0] v);
        logic signed [R_W-1:0] s;
        s = (v + (v[R_W-1] ? (HALF - R_W'(1)) : HALF)) >>> SH;
        return s[SUM_W-1:0];
    endfunction

    always_comb begin
        logic signed [31:0] p_xx, p_yy, p_zz, p_wx, p_wy, p_wz;
        logic signed [31:0] p_yz, p_zy, p_xz, p_zx, p_xy, p_yx;
        p_xx = i_cond.qx * i_cond.vx;
        p_yy = i_cond.qy * i_cond.vy;
        p_zz = i_cond.qz * i_cond.vz;
        p_wx = i_cond.qw * i_cond.vx;
        p_wy = i_cond.qw * i_cond.vy;
        p_wz = i_cond.qw * i_cond.vz;
        p_yz = i_cond.qy * i_cond.vz;
        p_zy = i_cond.qz * i_cond.vy;
        p_xz = i_cond.qx * i_cond.vz;
        p_zx = i_cond.qz * i_cond.vx;
        p_xy = i_cond.qx * i_cond.vy;
        p_yx = i_cond.qy * i_cond.vx;
        n_tw = -T_W'(p_xx) - T_W'(p_yy) - T_W'(p_zz);
        n_tx =  T_W'(p_wx) + T_W'(p_yz) - T_W'(p_zy);
        n_ty =  T_W'(p_wy) - T_W'(p_xz) + T_W'(p_zx);
        n_tz =  T_W'(p_wz) + T_W'(p_xy) - T_W'(p_yx);
    end

    always_comb begin
        logic signed [R_W-2:0] m_wx, m_xw, m_yz, m_zy;
        logic signed [R_W-2:0] m_wy, m_xz, m_yw, m_zx;
        logic signed [R_W-2:0] m_wz, m_xy, m_yx, m_zw;
        m_wx = r_tw * r_c2.qx;
        m_xw = r_tx * r_c2.qw;
        m_yz = r_ty * r_c2.qz;
        m_zy = r_tz * r_c2.qy;
        m_wy = r_tw * r_c2.qy;
        m_xz = r_tx * r_c2.qz;
        m_yw = r_ty * r_c2.qw;
        m_zx = r_tz * r_c2.qx;
        m_wz = r_tw * r_c2.qz;
        m_xy = r_tx * r_c2.qy;
        m_yx = r_ty * r_c2.qx;
        m_zw = r_tz * r_c2.qw;
        n_rx = -R_W'(m_wx) + R_W'(m_xw) - R_W'(m_yz) + R_W'(m_zy);
        n_ry = -R_W'(m_wy) + R_W'(m_xz) + R_W'(m_yw) - R_W'(m_zx);
        n_rz = -R_W'(m_wz) - R_W'(m_xy) + R_W'(m_yx) + R_W'(m_zw);
    end

    always_comb begin
        n_px = sat16(rnd(r_rx) + SUM_W'(r_c3.hx));
        n_py = sat16(rnd(r_ry) + SUM_W'(r_c3.hy));
        n_pz = sat16(rnd(r_rz) + SUM_W'(r_c3.hz));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_c2 <= i_cond;
            r_tw <= n_tw;
            r_tx <= n_tx;
            r_ty <= n_ty;
            r_tz <= n_tz;
        end
        if (r_v2) begin
            r_c3 <= r_c2;
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_rz <= n_rz;
        end
        if (r_v3) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
        end
    end

    assign o_valid  = r_v4;
    assign o_pose_x = r_px;
    assign o_pose_y = r_py;
    assign o_pose_z = r_pz;

endmodule

// File: hw/rtl/hrwp_mount.sv
// ----------------------------------------------------------------------------
// Head-relative wrist pose: mount rotation pipeline
// Hamilton product of the head quaternion and the per-hand mount quaternion,
// rounded and saturated, delayed to line up with the position pipeline.
// ----------------------------------------------------------------------------
module hrwp_mount (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  hrwp_pkg::t_cond      i_cond,
    output logic signed [15:0]   o_rot_w,
    output logic signed [15:0]   o_rot_x,
    output logic signed [15:0]   o_rot_y,
    output logic signed [15:0]   o_rot_z
);
    import hrwp_pkg::*;

    localparam logic signed [M_W-1:0] HALF = M_W'(1) <<< (MOUNT_FRAC - 1);

    logic                  r_v2, r_v3;
    logic signed [M_W-1:0] r_sw, r_sx, r_sy, r_sz;
    logic signed [M_W-1:0] n_sw, n_sx, n_sy, n_sz;
    logic signed [D_W-1:0] r_w3, r_x3, r_y3, r_z3;
    logic signed [D_W-1:0] r_w4, r_x4, r_y4, r_z4;

    function automatic logic signed [D_W-1:0] rnd_sat(input logic signed [M_W-1:0] v);
        logic signed [M_W-1:0] s;
        s = (v + (v[M_W-1] ? (HALF - M_W'(1)) : HALF)) >>> MOUNT_FRAC;
        return sat16(s[SUM_W-1:0]);
    endfunction

    always_comb begin
        logic signed [C_W-1:0]   b0, b1, b2, b3;
        logic signed [M_W-2:0]   w0, w1, w2, w3, x0, x1, x2, x3;
        logic signed [M_W-2:0]   y0, y1, y2, y3, z0, z1, z2, z3;
        b0 = mount_coef(i_cond.left, MQ_W);
        b1 = mount_coef(i_cond.left, MQ_X);
        b2 = mount_coef(i_cond.left, MQ_Y);
        b3 = mount_coef(i_cond.left, MQ_Z);
        w0 = i_cond.qw * b0;
        w1 = i_cond.qx * b1;
        w2 = i_cond.qy * b2;
        w3 = i_cond.qz * b3;
        x0 = i_cond.qw * b1;
        x1 = i_cond.qx * b0;
        x2 = i_cond.qy * b3;
        x3 = i_cond.qz * b2;
        y0 = i_cond.qw * b2;
        y1 = i_cond.qx * b3;
        y2 = i_cond.qy * b0;
        y3 = i_cond.qz * b1;
        z0 = i_cond.qw * b3;
        z1 = i_cond.qx * b2;
        z2 = i_cond.qy * b1;
        z3 = i_cond.qz * b0;
        n_sw = M_W'(w0) - M_W'(w1) - M_W'(w2) - M_W'(w3);
        n_sx = M_W'(x0) + M_W'(x1) + M_W'(x2) - M_W'(x3);
        n_sy = M_W'(y0) - M_W'(y1) + M_W'(y2) + M_W'(y3);
        n_sz = M_W'(z0) + M_W'(z1) - M_W'(z2) + M_W'(z3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_sw <= n_sw;
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_sz <= n_sz;
        end
        if (r_v2) begin
            r_w3 <= rnd_sat(r_sw);
            r_x3 <= rnd_sat(r_sx);
            r_y3 <= rnd_sat(r_sy);
            r_z3 <= rnd_sat(r_sz);
        end
        if (r_v3) begin
            r_w4 <= r_w3;
            r_x4 <= r_x3;
            r_y4 <= r_y3;
            r_z4 <= r_z3;
        end
    end

    assign o_rot_w = r_w4;
    assign o_rot_x = r_x4;
    assign o_rot_y = r_y4;
    assign o_rot_z = r_z4;

endmodule

// File: hw/rtl/head_relative_wrist_pose_unit.sv
// ----------------------------------------------------------------------------
// Head-relative wrist pose unit
// World controller pose from a head pose and a head-local wrist offset.
// ----------------------------------------------------------------------------
// The unit takes one head pose and wrist offset in every clock cycle and
// never raises o_busy. Each result appears on the output ports, marked by
// o_valid, for exactly one cycle; the receiver cannot hold it off. Each
// item passes through four register stages: input conditioning, the first
// and the second quaternion multiplier banks, and rounding with translation
// and saturation. The hand selection register is to be written by the user
// through the APB port only while no item is in flight; the block itself
// does not enforce this.
`include "head_relative_wrist_pose_unit_defines.svh"

module head_relative_wrist_pose_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic signed [15:0]   i_head_x,
    input  logic signed [15:0]   i_head_y,
    input  logic signed [15:0]   i_head_z,
    input  logic signed [15:0]   i_head_qw,
    input  logic signed [15:0]   i_head_qx,
    input  logic signed [15:0]   i_head_qy,
    input  logic signed [15:0]   i_head_qz,
    input  logic signed [15:0]   i_wrist_x,
    input  logic signed [15:0]   i_wrist_y,
    input  logic signed [15:0]   i_wrist_z,
    input  logic                 i_wrist_tracked,
    output logic                 o_valid,
    output logic signed [15:0]   o_pose_x,
    output logic signed [15:0]   o_pose_y,
    output logic signed [15:0]   o_pose_z,
    output logic signed [15:0]   o_rot_w,
    output logic signed [15:0]   o_rot_x,
    output logic signed [15:0]   o_rot_y,
    output logic signed [15:0]   o_rot_z
);
    import hrwp_pkg::*;

    localparam logic ADDR_HAND = 1'b0;

    logic  r_hand_is_left;
    logic  cfg_wr;
    logic  accept;
    logic  cond_valid;
    t_cond cond;

    assign pready = 1'b1;
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hand_is_left <= 1'b0;
        end else if (cfg_wr && (paddr[2] == ADDR_HAND)) begin
            r_hand_is_left <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ADDR_HAND) begin
            prdata[0] = r_hand_is_left;
        end
    end

    hrwp_cond u_cond (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (accept),
        .i_left          (r_hand_is_left),
        .i_head_x        (i_head_x),
        .i_head_y        (i_head_y),
        .i_head_z        (i_head_z),
        .i_head_qw       (i_head_qw),
        .i_head_qx       (i_head_qx),
        .i_head_qy       (i_head_qy),
        .i_head_qz       (i_head_qz),
        .i_wrist_x       (i_wrist_x),
        .i_wrist_y       (i_wrist_y),
        .i_wrist_z       (i_wrist_z),
        .i_wrist_tracked (i_wrist_tracked),
        .o_valid         (cond_valid),
        .o_cond          (cond)
    );

    hrwp_rot u_rot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cond_valid),
        .i_cond   (cond),
        .o_valid  (o_valid),
        .o_pose_x (o_pose_x),
        .o_pose_y (o_pose_y),
        .o_pose_z (o_pose_z)
    );

    hrwp_mount u_mount (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cond_valid),
        .i_cond  (cond),
        .o_rot_w (o_rot_w),
        .o_rot_x (o_rot_x),
        .o_rot_y (o_rot_y),
        .o_rot_z (o_rot_z)
    );

    `HRWP_ASSERT(result_follows_a, accept |-> ##4 o_valid)
    `HRWP_ASSERT(no_spurious_result_a, !accept |-> ##4 !o_valid)
    `HRWP_ASSERT(hand_write_a,
        (cfg_wr && (paddr[2] == ADDR_HAND)) |=> (r_hand_is_left == $past(pwdata[0])))
    `HRWP_ASSERT_ANY(reset_clears_a, !i_rst_n |=> !o_valid)

endmodule
